FILE: hw/rtl/luw_pkg.sv
package luw_pkg;

    localparam int MAX_STRING_DEF = 4096;
    localparam int ALPHABET_DEF   = 256;

    localparam int CHAR_W    = 8;
    localparam int LENGTH_W  = 13;
    localparam int START_W   = 12;
    localparam int CODE_SPAN = 256;

    typedef logic [CODE_SPAN-1:0][CHAR_W-1:0] code_tab_t;

    typedef struct packed {
        logic final_result;
        logic length_overflow;
    } luw_flags_t;

    // Folds every byte value onto the alphabet by counting, with no divider.
    function automatic code_tab_t build_code_tab(input int alpha);
        code_tab_t tab;
        int        r;
        r = 0;
        for (int i = 0; i < CODE_SPAN; i++)
        begin
            tab[i] = r[CHAR_W-1:0];
            r = (r + 1 == alpha) ? 0 : r + 1;
        end
        return tab;
    endfunction

endpackage

FILE: hw/rtl/luw_pos_table.sv
module luw_pos_table
    import luw_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int IDX_W    = 12,
    parameter int CODE_W   = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [CODE_W-1:0] rd_code,
    input  logic              wr_en,
    input  logic [CODE_W-1:0] wr_code,
    input  logic [IDX_W-1:0]  wr_pos,
    output logic [IDX_W-1:0]  rd_pos
);

    logic [IDX_W-1:0] mem [ALPHABET];
    logic [IDX_W-1:0] mem_rd_reg;
    logic [IDX_W-1:0] bypass_pos_reg;
    logic             bypass_hit_reg;
    logic             bypass_hit_next;

    // A write landing on the same edge as the read is not yet visible in the array.
    assign bypass_hit_next = wr_en && (wr_code == rd_code);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_code] <= wr_pos;
        end
        if (rd_en)
        begin
            mem_rd_reg     <= mem[rd_code];
            bypass_pos_reg <= wr_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_hit_reg <= bypass_hit_next;
        end
    end

    assign rd_pos = bypass_hit_reg ? bypass_pos_reg : mem_rd_reg;

endmodule

FILE: hw/rtl/luw_window.sv
module luw_window
    import luw_pkg::*;
#(
    parameter int MAX_STRING = MAX_STRING_DEF,
    parameter int ALPHABET   = ALPHABET_DEF,
    parameter int POS_W      = 13,
    parameter int IDX_W      = 12,
    parameter int CODE_W     = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [CODE_W-1:0] code,
    input  logic              last,
    input  logic [IDX_W-1:0]  last_pos,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_pos,
    output logic [POS_W-1:0]  best_post,
    output logic [POS_W-1:0]  run_post,
    output logic [IDX_W-1:0]  start_post,
    output luw_flags_t        flags_post
);

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    run_reg;
    logic [POS_W-1:0]    best_reg;
    logic [IDX_W-1:0]    start_reg;
    logic                ovf_reg;
    logic [ALPHABET-1:0] seen_reg;

    logic             full;
    logic [POS_W-1:0] win_start;
    logic [POS_W-1:0] last_ext;
    logic             repeat_hit;
    logic [POS_W-1:0] run_step;
    logic [POS_W-1:0] pos_inc;
    logic             longer;
    logic [POS_W-1:0] start_step;

    assign full       = (pos_reg >= POS_W'(MAX_STRING));
    assign win_start  = pos_reg - run_reg;
    assign last_ext   = POS_W'(last_pos);
    assign repeat_hit = seen_reg[code] && (last_ext >= win_start);
    assign run_step   = repeat_hit ? (pos_reg - last_ext) : (run_reg + 1'b1);
    assign pos_inc    = pos_reg + 1'b1;
    assign longer     = (run_step > best_reg);
    assign start_step = pos_inc - run_step;

    always_comb
    begin
        flags_post.final_result = last;
        if (full)
        begin
            run_post                   = run_reg;
            best_post                  = best_reg;
            start_post                 = start_reg;
            flags_post.length_overflow = 1'b1;
        end
        else
        begin
            run_post                   = run_step;
            best_post                  = longer ? run_step : best_reg;
            start_post                 = longer ? start_step[IDX_W-1:0] : start_reg;
            flags_post.length_overflow = ovf_reg;
        end
    end

    assign wr_en  = fire && !full;
    assign wr_pos = pos_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            run_reg   <= '0;
            best_reg  <= '0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
            seen_reg  <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                run_reg   <= '0;
                best_reg  <= '0;
                start_reg <= '0;
                ovf_reg   <= 1'b0;
                seen_reg  <= '0;
            end
            else
            begin
                run_reg   <= run_post;
                best_reg  <= best_post;
                start_reg <= start_post;
                ovf_reg   <= flags_post.length_overflow;
                if (!full)
                begin
                    pos_reg        <= pos_inc;
                    seen_reg[code] <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/longest_unique_char_window.sv
// An item is registered in stage 1 when accepted and its result when stage 1 fires; a
// stalled result holds the item behind it in place. Throughput: one item per cycle
// unless the result stalls; the last-position table is read at the accepting
// edge and the write of the item just ahead is forwarded past that registered read.
// Reset (asynchronous, active low) clears every valid bit, the position, the lengths,
// the start and the overflow flag; table entries stay unwritten and are never used.
module longest_unique_char_window
    import luw_pkg::*;
#(
    parameter int MAX_STRING = MAX_STRING_DEF,
    parameter int ALPHABET   = ALPHABET_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                end_of_string,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [LENGTH_W-1:0] longest_length,
    output logic [LENGTH_W-1:0] window_length,
    output logic [START_W-1:0]  longest_start,
    output logic                final_result,
    output logic                length_overflow
);

    localparam int        POS_W    = $clog2(MAX_STRING + 1);
    localparam int        IDX_W    = $clog2(MAX_STRING);
    localparam int        CODE_W   = $clog2(ALPHABET);
    localparam code_tab_t CODE_TAB = build_code_tab(ALPHABET);

    logic              accept;
    logic              s1_fire;
    logic [CHAR_W-1:0] code_full;
    logic [CODE_W-1:0] code_idx;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CODE_W-1:0] s1_code_reg;
    logic              s1_last_reg;

    logic              result_valid_reg;
    logic              result_valid_next;
    logic [POS_W-1:0]  res_best_reg;
    logic [POS_W-1:0]  res_run_reg;
    logic [IDX_W-1:0]  res_start_reg;
    luw_flags_t        res_flags_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_pos;
    logic [IDX_W-1:0]  last_pos;
    logic [POS_W-1:0]  best_post;
    logic [POS_W-1:0]  run_post;
    logic [IDX_W-1:0]  start_post;
    luw_flags_t        flags_post;

    logic [POS_W+LENGTH_W-1:0] best_ext;
    logic [POS_W+LENGTH_W-1:0] run_ext;
    logic [IDX_W+START_W-1:0]  start_ext;

    assign code_full = CODE_TAB[char_code];
    assign code_idx  = code_full[CODE_W-1:0];

    assign s1_fire = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign stall   = s1_valid_reg && !s1_fire;
    assign accept  = valid && !stall;

    assign s1_valid_next     = accept || (s1_valid_reg && !s1_fire);
    assign result_valid_next = s1_fire || (result_valid_reg && result_stall);

    luw_pos_table #(
        .ALPHABET (ALPHABET),
        .IDX_W    (IDX_W),
        .CODE_W   (CODE_W)
    ) u_pos_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_code (code_idx),
        .wr_en   (wr_en),
        .wr_code (s1_code_reg),
        .wr_pos  (wr_pos),
        .rd_pos  (last_pos)
    );

    luw_window #(
        .MAX_STRING (MAX_STRING),
        .ALPHABET   (ALPHABET),
        .POS_W      (POS_W),
        .IDX_W      (IDX_W),
        .CODE_W     (CODE_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .code       (s1_code_reg),
        .last       (s1_last_reg),
        .last_pos   (last_pos),
        .wr_en      (wr_en),
        .wr_pos     (wr_pos),
        .best_post  (best_post),
        .run_post   (run_post),
        .start_post (start_post),
        .flags_post (flags_post)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg <= code_idx;
            s1_last_reg <= end_of_string;
        end
        if (s1_fire)
        begin
            res_best_reg  <= best_post;
            res_run_reg   <= run_post;
            res_start_reg <= start_post;
            res_flags_reg <= flags_post;
        end
    end

    assign best_ext  = {{LENGTH_W{1'b0}}, res_best_reg};
    assign run_ext   = {{LENGTH_W{1'b0}}, res_run_reg};
    assign start_ext = {{START_W{1'b0}}, res_start_reg};

    assign result_valid    = result_valid_reg;
    assign longest_length  = best_ext[LENGTH_W-1:0];
    assign window_length   = run_ext[LENGTH_W-1:0];
    assign longest_start   = start_ext[START_W-1:0];
    assign final_result    = res_flags_reg.final_result;
    assign length_overflow = res_flags_reg.length_overflow;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (res_run_reg <= res_best_reg))
        else $error("Window length exceeds the longest length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (res_best_reg <= POS_W'(MAX_STRING)))
        else $error("Longest length exceeds the string bound.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> !stall)
        else $error("Input stalled while the result register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> result_valid_reg)
        else $error("Processed item produced no result.");

endmodule
